// ===== rtl/smsenc_pkg.sv =====
// Shared types and constants for the SMS user-data encoder.
`timescale 1ns / 1ps
`default_nettype none

package smsenc_pkg;

	// Coding modes
	localparam logic MODE_GSM7 = 1'b0;
	localparam logic MODE_UCS2 = 1'b1;

	// UTF-8 continuation byte tag (10xxxxxx)
	localparam logic [1:0] CONT_TAG = 2'b10;

	// One request from front to back: one or two result bytes of one input item
	typedef struct packed {
		logic       two;      // two results; b0 first, then b1
		logic [7:0] b0;
		logic [7:0] b1;
		logic       no_data;  // single empty result that only closes the message
		logic       eom;      // last result of this request closes the message
	} req_t;

endpackage

`default_nettype wire

// ===== rtl/smsenc_front.sv =====
// Front end: takes input bytes, keeps packing and UTF-8 state, builds requests.
`timescale 1ns / 1ps
`default_nettype none

module smsenc_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              coding_mode,
	input  wire              accept,
	input  wire  [7:0]       in_byte,
	input  wire              last_of_message,
	output logic             push,
	output smsenc_pkg::req_t req
);
	import smsenc_pkg::*;

	function automatic logic [3:0] lead_ones(input logic [7:0] b);
		priority casez (b)
			8'b0???????: lead_ones = 4'd0;
			8'b10??????: lead_ones = 4'd1;
			8'b110?????: lead_ones = 4'd2;
			8'b1110????: lead_ones = 4'd3;
			8'b11110???: lead_ones = 4'd4;
			8'b111110??: lead_ones = 4'd5;
			8'b1111110?: lead_ones = 4'd6;
			8'b11111110: lead_ones = 4'd7;
			default:     lead_ones = 4'd8;
		endcase
	endfunction

	logic [6:0]  pend_bits_q, pend_bits_d;
	logic [2:0]  pend_cnt_q, pend_cnt_d;
	logic [2:0]  rem_q, rem_d;
	logic [15:0] code_q, code_d;
	logic        err_q, err_d;

	logic [13:0] acc;
	logic [3:0]  ones;
	logic [7:0]  lead;
	logic [1:0]  n;
	logic [7:0]  r0, r1;
	logic        nd;

	always_comb begin
		pend_bits_d = pend_bits_q;
		pend_cnt_d  = pend_cnt_q;
		rem_d       = rem_q;
		code_d      = code_q;
		err_d       = err_q;
		n           = 2'd0;
		r0          = 8'h00;
		r1          = 8'h00;
		nd          = 1'b0;
		acc         = {7'b0, pend_bits_q} | ({7'b0, in_byte[6:0]} << pend_cnt_q);
		ones        = lead_ones(in_byte);
		lead        = 8'h00;

		unique case (ones)
			4'd2:    lead = in_byte & 8'h1F;
			4'd3:    lead = in_byte & 8'h0F;
			4'd4:    lead = in_byte & 8'h07;
			4'd5:    lead = in_byte & 8'h03;
			4'd6:    lead = in_byte & 8'h01;
			default: lead = 8'h00;
		endcase

		if (coding_mode == MODE_GSM7) begin
			if (pend_cnt_q != 3'd0) begin
				r0          = acc[7:0];
				n           = 2'd1;
				pend_bits_d = {1'b0, acc[13:8]};
				pend_cnt_d  = pend_cnt_q - 3'd1;
			end else begin
				pend_bits_d = in_byte[6:0];
				pend_cnt_d  = 3'd7;
			end
			// flush the partial octet, zero padded
			if (last_of_message && pend_cnt_d != 3'd0) begin
				if (n == 2'd0) begin
					r0 = {1'b0, pend_bits_d};
				end else begin
					r1 = {1'b0, pend_bits_d};
				end
				n = n + 2'd1;
			end
		end else begin
			if (rem_q == 3'd0) begin
				if (ones <= 4'd1 || ones == 4'd8) begin
					// single-byte sequence, code is the byte itself
					if (in_byte != 8'h00) begin
						r0 = 8'h00;
						r1 = in_byte;
						n  = 2'd2;
					end
					code_d = 16'h0000;
					err_d  = 1'b0;
				end else begin
					code_d = {8'h00, lead};
					rem_d  = ones[2:0] - 3'd1;
					err_d  = 1'b0;
				end
			end else begin
				err_d  = err_q | (in_byte[7:6] != CONT_TAG);
				code_d = {code_q[9:0], in_byte[5:0]};
				rem_d  = rem_q - 3'd1;
				if (rem_d == 3'd0) begin
					if (!err_d && code_d != 16'h0000) begin
						r0 = code_d[15:8];
						r1 = code_d[7:0];
						n  = 2'd2;
					end
					code_d = 16'h0000;
					err_d  = 1'b0;
				end
			end
		end

		if (last_of_message) begin
			pend_bits_d = 7'd0;
			pend_cnt_d  = 3'd0;
			rem_d       = 3'd0;
			code_d      = 16'h0000;
			err_d       = 1'b0;
			if (n == 2'd0) begin
				nd = 1'b1;
				n  = 2'd1;
			end
		end
	end

	assign push        = accept && (n != 2'd0);
	assign req.two     = (n == 2'd2);
	assign req.b0      = r0;
	assign req.b1      = r1;
	assign req.no_data = nd;
	assign req.eom     = last_of_message;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= 7'd0;
			pend_cnt_q  <= 3'd0;
			rem_q       <= 3'd0;
			code_q      <= 16'h0000;
			err_q       <= 1'b0;
		end else if (accept) begin
			pend_bits_q <= pend_bits_d;
			pend_cnt_q  <= pend_cnt_d;
			rem_q       <= rem_d;
			code_q      <= code_d;
			err_q       <= err_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/smsenc_fifo.sv =====
// Request queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none

module smsenc_fifo #(
	parameter int DEPTH = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  smsenc_pkg::req_t wdata,
	input  wire              pop,
	output smsenc_pkg::req_t rdata,
	output logic             empty,
	output logic             full
);
	import smsenc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	req_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == FULL_CNT);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/smsenc_back.sv =====
// Back end: splits requests into result bytes behind an output register.
`timescale 1ns / 1ps
`default_nettype none

module smsenc_back (
	input  wire              clk,
	input  wire              arst_n,
	input  smsenc_pkg::req_t head,
	input  wire              empty,
	output logic             pop,
	output logic             out_valid,
	input  wire              out_stall,
	output logic [7:0]       out_byte,
	output logic             no_data,
	output logic             end_of_message
);
	import smsenc_pkg::*;

	logic       valid_q;
	logic       sub_q;    // first byte of a two-byte request already sent
	logic [7:0] byte_q;
	logic       nd_q;
	logic       eom_q;
	logic       load;
	logic       first_of_two;

	assign load         = !valid_q || !out_stall;
	assign first_of_two = head.two && !sub_q;
	assign pop          = load && !empty && !first_of_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				sub_q <= first_of_two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			if (first_of_two) begin
				byte_q <= head.b0;
				nd_q   <= 1'b0;
				eom_q  <= 1'b0;
			end else begin
				byte_q <= sub_q ? head.b1 : head.b0;
				nd_q   <= head.no_data;
				eom_q  <= head.eom;
			end
		end
	end

	assign out_valid      = valid_q;
	assign out_byte       = byte_q;
	assign no_data        = nd_q;
	assign end_of_message = eom_q;

endmodule

`default_nettype wire

// ===== rtl/sms_user_data_encoder.sv =====
// Top level of the SMS user-data encoder (GSM 7-bit packing / UTF-8 to UCS2).
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  in       | sink      | in_valid/in_stall  | in_byte, last_of_message
//  out      | source    | out_valid/out_stall| out_byte, no_data, end_of_message
//  cfg      | sink      | cfg_valid/cfg_ready| coding_mode
//
// One input byte is accepted per cycle while the request queue has room.
// Each byte yields zero, one or two result bytes; the back end sends one per cycle
// while out_stall is low, and each result passes the request queue, then the output register.
// in_stall is high while the QUEUE_DEPTH-entry request queue is full.
// Reset selects 7-bit mode and clears all packing and UTF-8 state.
`timescale 1ns / 1ps
`default_nettype none

module sms_user_data_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] in_byte,
	input  wire        last_of_message,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] out_byte,
	output logic       no_data,
	output logic       end_of_message,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire        coding_mode
);
	import smsenc_pkg::*;

	logic mode_q;
	logic accept;
	logic push, pop, q_empty, q_full;
	req_t req, head;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GSM7;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= coding_mode;
		end
	end

	smsenc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.coding_mode     (mode_q),
		.accept          (accept),
		.in_byte         (in_byte),
		.last_of_message (last_of_message),
		.push            (push),
		.req             (req)
	);

	smsenc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (req),
		.pop    (pop),
		.rdata  (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	smsenc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.empty          (q_empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.no_data        (no_data),
		.end_of_message (end_of_message)
	);

	// an empty result only ever closes a message and carries a zero byte
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_data |-> end_of_message && out_byte == 8'h00)
		else $error("empty result without end mark or with data");

	// the back end never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("request queue underflow");

	// the last byte of a message always leaves a request behind
	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_of_message |=> !q_empty)
		else $error("message end produced no request");

endmodule

`default_nettype wire
